[rtl/lcg128_pkg.sv]
package lcg128_pkg;

	// Field widths
	localparam int STATE_W = 128;
	localparam int RAW_W   = 64;
	localparam int BOUND_W = 31;
	localparam int SEED_LO_W = 64;
	localparam int SEED_HI_W = 63;

	// Two multiplier bits are consumed per step
	localparam int DIGIT_W  = 2;
	localparam int MUL_STEPS = STATE_W / DIGIT_W;
	localparam int CNT_W    = $clog2(MUL_STEPS);

	// Fixed multiplier of the generator
	localparam logic [STATE_W-1:0] LCG_MULT = 128'h12e15e35b500f16e_2e714eb2b37916a5;

	// Configuration register indexes
	localparam logic REG_SEED_LOW  = 1'b0;
	localparam logic REG_SEED_HIGH = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} seq_state_t;

	// Control from the sequencer to the serial units
	typedef struct packed {
		logic load;
		logic step;
	} ser_ctl_t;

endpackage

[rtl/lcg128_mul.sv]
module lcg128_mul import lcg128_pkg::*; (
	input  logic               clk,
	input  ser_ctl_t           ctl,
	input  logic [STATE_W-1:0] operand,
	output logic [STATE_W-1:0] product
);

	logic [STATE_W-1:0] s_q;
	logic [STATE_W-1:0] s3_q;
	logic [STATE_W-1:0] m_q;
	logic [STATE_W-1:0] acc_q;
	logic [STATE_W-1:0] addend;
	logic [DIGIT_W-1:0] digit;

	// Pick the partial product for the current multiplier digit
	assign digit = m_q[STATE_W-1 -: DIGIT_W];

	always_comb begin
		case (digit)
			2'd0: addend = '0;
			2'd1: addend = s_q;
			2'd2: addend = {s_q[STATE_W-2:0], 1'b0};
			2'd3: addend = s3_q;
			default: addend = '0;
		endcase
	end

	// Load operand and its triple, then accumulate Horner-style from the top digit
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			s_q   <= operand;
			s3_q  <= operand + {operand[STATE_W-2:0], 1'b0};
			m_q   <= LCG_MULT;
			acc_q <= '0;
		end else if (ctl.step) begin
			m_q   <= {m_q[STATE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
			acc_q <= {acc_q[STATE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + addend;
		end
	end

	assign product = acc_q;

endmodule

[rtl/lcg128_rem.sv]
module lcg128_rem import lcg128_pkg::*; (
	input  logic               clk,
	input  ser_ctl_t           ctl,
	input  logic [RAW_W-1:0]   dividend,
	input  logic [BOUND_W-1:0] divisor,
	output logic [BOUND_W-1:0] remainder,
	output logic               div_zero
);

	logic [RAW_W-1:0]   num_q;
	logic [BOUND_W-1:0] den_q;
	logic [BOUND_W-1:0] rem_q;
	logic [BOUND_W:0]   rem_shift;
	logic [BOUND_W:0]   rem_sub;

	// Bring in the next dividend bit and try the subtraction
	assign rem_shift = {rem_q, num_q[RAW_W-1]};
	assign rem_sub   = rem_shift - {1'b0, den_q};

	// Restoring remainder, one dividend bit per step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (ctl.step) begin
			num_q <= {num_q[RAW_W-2:0], 1'b0};
			if (rem_shift >= {1'b0, den_q}) begin
				rem_q <= rem_sub[BOUND_W-1:0];
			end else begin
				rem_q <= rem_shift[BOUND_W-1:0];
			end
		end
	end

	assign div_zero  = (den_q == '0);
	assign remainder = div_zero ? '0 : rem_q;

endmodule

[rtl/lehmer128_random_generator.sv]
// 128-bit Lehmer generator. Each transaction on the input channel returns the upper
// 64 bits of the current state as raw_value, raw_value modulo bound as bounded_value
// (zero with bound_error set when bound is zero), and advances the state by one
// multiplication with the fixed 128-bit multiplier. The accepting edge loads the serial
// units, 64 steps of the two-bit-per-cycle multiplier and the one-bit-per-cycle remainder
// unit follow, and the finish state then moves the result into the output register once
// that register is empty or its waiting result is being taken. One request
// is worked on at a time; the next one can be accepted while a result waits to be taken.
// Writing seed_low or seed_high reloads the state with (seed << 1) | 1; after reset the
// state is 1. Write the seed only while no request is in progress.
module lehmer128_random_generator import lcg128_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BOUND_W-1:0]   bound,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [RAW_W-1:0]     raw_value,
	output logic [BOUND_W-1:0]   bounded_value,
	output logic                 bound_error,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [SEED_LO_W-1:0] cfg_data
);

	seq_state_t         state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [STATE_W-1:0] gen_q;
	logic [SEED_LO_W-1:0] seed_low_q;
	logic [SEED_HI_W-1:0] seed_high_q;
	logic               out_valid_q;
	logic [RAW_W-1:0]   raw_q;
	logic [BOUND_W-1:0] bval_q;
	logic               berr_q;
	ser_ctl_t           ctl;
	logic               out_room;
	logic               finish;
	logic [STATE_W-1:0] product;
	logic [BOUND_W-1:0] remainder;
	logic               div_zero;

	lcg128_mul u_mul (
		.clk     (clk),
		.ctl     (ctl),
		.operand (gen_q),
		.product (product)
	);

	lcg128_rem u_rem (
		.clk       (clk),
		.ctl       (ctl),
		.dividend  (gen_q[STATE_W-1 -: RAW_W]),
		.divisor   (bound),
		.remainder (remainder),
		.div_zero  (div_zero)
	);

	assign out_room = !out_valid_q || !out_stall;

	// Sequence load, serial steps and result write
	always_comb begin
		state_d  = state_q;
		ctl.load = 1'b0;
		ctl.step = 1'b0;
		finish   = 1'b0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				ctl.step = 1'b1;
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_room) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				cnt_q <= '0;
			end else if (ctl.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Hold seed and generator state; reload on seed write, advance on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q  <= '0;
			seed_high_q <= '0;
			gen_q       <= STATE_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SEED_LOW: begin
					seed_low_q <= cfg_data;
					gen_q      <= {seed_high_q, cfg_data, 1'b1};
				end
				REG_SEED_HIGH: begin
					seed_high_q <= cfg_data[SEED_HI_W-1:0];
					gen_q       <= {cfg_data[SEED_HI_W-1:0], seed_low_q, 1'b1};
				end
				default: ;
			endcase
		end else if (finish) begin
			gen_q <= product;
		end
	end

	// Output register: drop valid when taken, fill on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			raw_q  <= gen_q[STATE_W-1 -: RAW_W];
			bval_q <= remainder;
			berr_q <= div_zero;
		end
	end

	assign out_valid     = out_valid_q;
	assign raw_value     = raw_q;
	assign bounded_value = bval_q;
	assign bound_error   = berr_q;

endmodule

[rtl/lcg128_chk.sv]
module lcg128_chk import lcg128_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [BOUND_W-1:0]   bound,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [RAW_W-1:0]     raw_value,
	input logic [BOUND_W-1:0]   bounded_value,
	input logic                 bound_error,
	input logic                 cfg_wr_en,
	input logic                 cfg_index,
	input logic [SEED_LO_W-1:0] cfg_data
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A zero bound gives a zero reduced value
	a_zero_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bound_error |-> bounded_value == '0)
		else $error("nonzero reduced value with bound error");

	// After a transaction the input becomes stalled
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a request runs");

	// No result appears right after a transaction is accepted
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind lehmer128_random_generator lcg128_chk u_chk (.*);

[verif/tb.sv]
module tb;
	import lcg128_pkg::*;

	localparam logic [127:0] GEN_MULTIPLIER = 128'h12e15e35b500f16e_2e714eb2b37916a5;
	localparam int           STALL_LIMIT    = 5000;
	localparam int           LONG_HOLD      = 400;
	localparam int           DRAIN_CYCLES   = 100;

	typedef struct {
		logic [RAW_W-1:0]   raw;
		logic [BOUND_W-1:0] bounded;
		logic               err;
	} draw_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BOUND_W-1:0]   bound = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [RAW_W-1:0]     raw_value;
	logic [BOUND_W-1:0]   bounded_value;
	logic                 bound_error;
	logic                 cfg_wr_en = 1'b0;
	logic                 cfg_index = REG_SEED_LOW;
	logic [SEED_LO_W-1:0] cfg_data = '0;

	// generator mirror: seed registers and 128-bit state
	logic [SEED_LO_W-1:0] seed_lo = '0;
	logic [SEED_HI_W-1:0] seed_hi = '0;
	logic [127:0]         gen_state = 128'd1;

	logic [BOUND_W-1:0] bound_q[$];
	draw_t              draw_q[$];

	bit req_taken    = 1'b0;
	bit sender_hold  = 1'b0;
	int send_idle_pct = 0;
	int rx_idle_pct   = 0;
	int rx_hold_left  = 0;
	int in_accepts    = 0;
	int err_cnt       = 0;
	int idle_cycles   = 0;

	lehmer128_random_generator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.bound        (bound),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.raw_value    (raw_value),
		.bounded_value(bounded_value),
		.bound_error  (bound_error),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Return the draw for one request and advance the mirrored state
	function automatic draw_t draw_and_advance(input logic [BOUND_W-1:0] b);
		draw_t        d;
		logic [63:0]  rem;
		d.raw = gen_state[127:64];
		d.err = (b == '0);
		rem = d.err ? 64'd0 : d.raw % {33'd0, b};
		d.bounded = rem[BOUND_W-1:0];
		gen_state = gen_state * GEN_MULTIPLIER;
		return d;
	endfunction

	// Pick a bound: zero, small moduli, powers of two and top edges; over half full range
	function automatic logic [BOUND_W-1:0] pick_bound();
		int          sel;
		logic [31:0] r;
		sel = $urandom_range(99);
		r = $urandom;
		if (sel < 6)
			return '0;
		else if (sel < 30)
			return BOUND_W'($urandom_range(16, 1));
		else if (sel < 40)
			return BOUND_W'(1) << $urandom_range(BOUND_W - 1);
		else if (sel < 46)
			return {BOUND_W{1'b1}} - BOUND_W'($urandom_range(3));
		else
			return r[BOUND_W-1:0];
	endfunction

	// Write one seed register and reload the mirrored state
	task automatic write_seed(input logic idx, input logic [SEED_LO_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_SEED_LOW)
			seed_lo = val;
		else
			seed_hi = val[SEED_HI_W-1:0];
		gen_state = {seed_hi, seed_lo, 1'b1};
	endtask

	// Wait until no request is queued, offered or outstanding
	task automatic wait_drained();
		@(posedge clk);
		while (bound_q.size() != 0 || in_valid || draw_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic queue_random(input int n);
		repeat (n) bound_q.push_back(pick_bound());
	endtask

	// Track accepted requests and predict their draws
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			draw_q.push_back(draw_and_advance(bound));
			req_taken = 1'b1;
			in_accepts++;
		end
	end

	// Offer requests; hold the current one until it is taken
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			req_taken = 1'b0;
			if (arst_n && bound_q.size() != 0 && !sender_hold &&
			    $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				bound    <= bound_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random, or for a long stretch on request
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left = rx_hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Check each result transaction against the oldest predicted draw
	always @(posedge clk) begin
		draw_t d;
		if (arst_n && out_valid && !out_stall) begin
			if (draw_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result: raw=%h bounded=%h err=%b",
					         raw_value, bounded_value, bound_error);
			end else begin
				d = draw_q.pop_front();
				if (raw_value !== d.raw || bounded_value !== d.bounded ||
				    bound_error !== d.err) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: raw exp %h got %h, bounded exp %h got %h, err exp %b got %b",
						         d.raw, raw_value, d.bounded, bounded_value, d.err, bound_error);
				end
			end
		end
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int base;
		send_idle_pct = 16;
		rx_idle_pct   = 68;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset seed: edges of the bound, zero bound, alternating bits
		bound_q = '{31'd0, 31'd1, 31'd2, 31'd3, 31'h7fffffff, 31'h40000000,
		            31'h55555555, 31'h2aaaaaaa, 31'd7, 31'd1000};
		wait_drained();

		// all-ones seed; top bit of the high word must be dropped
		write_seed(REG_SEED_LOW, '1);
		write_seed(REG_SEED_HIGH, '1);
		bound_q = '{31'd0, 31'h7fffffff, 31'd1, 31'h7ffffffe, 31'd13};
		wait_drained();

		// zero seed brings back the reset state
		write_seed(REG_SEED_HIGH, '0);
		write_seed(REG_SEED_LOW, '0);
		bound_q = '{31'h7fffffff, 31'd5, 31'd0};
		wait_drained();

		// random phase: busy sender, often-stalling receiver, with long hold and a full pause
		write_seed(REG_SEED_HIGH, {$urandom, $urandom});
		write_seed(REG_SEED_LOW, {$urandom, $urandom});
		base = in_accepts;
		queue_random(340);
		while (in_accepts < base + 60)
			@(posedge clk);
		rx_hold_left = LONG_HOLD;
		while (in_accepts < base + 200)
			@(posedge clk);
		sender_hold = 1'b1;
		while (in_valid || draw_q.size() != 0)
			@(posedge clk);
		sender_hold = 1'b0;
		wait_drained();

		// random phase: sparse sender, sparse receiver stalls
		send_idle_pct = 68;
		rx_idle_pct   = 16;
		write_seed(REG_SEED_LOW, {$urandom, $urandom});
		write_seed(REG_SEED_HIGH, {$urandom, $urandom});
		queue_random(340);
		wait_drained();

		// random phase: no idling on either side
		send_idle_pct = 0;
		rx_idle_pct   = 0;
		write_seed(REG_SEED_LOW, 64'haaaaaaaaaaaaaaaa);
		write_seed(REG_SEED_HIGH, 64'h5555555555555555);
		queue_random(345);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && draw_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
